### src/lifo_stack_with_search_and_counts_assert.svh
// assertion macros for the lifo stack block
// used by the top level and the prime test unit
`ifndef LIFO_STACK_WITH_SEARCH_AND_COUNTS_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_AND_COUNTS_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LSSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked on the clock edge after the antecedent
`define LSSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### src/lssc_pkg.sv
// shared constants and types for the lifo stack block
// no dependencies
package lssc_pkg;
  localparam int StackDepth = 64;
  localparam int ValueWidth = 16;
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  // request/response between the sequencer and the prime test unit
  typedef struct packed {
    logic start;
  } prime_req_t;
  typedef struct packed {
    logic busy;
    logic done;
    logic is_prime;
  } prime_rsp_t;
endpackage

### src/lssc_prime.sv
// primality test by trial division with a shared restoring divider
// depends on lssc_pkg and the assertion header
`include "lifo_stack_with_search_and_counts_assert.svh"
module lssc_prime #(
  parameter int VALUE_WIDTH = lssc_pkg::ValueWidth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lssc_pkg::prime_req_t          req,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output lssc_pkg::prime_rsp_t          rsp
);
  localparam int W = VALUE_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TRY = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [W-1:0] n_r, n_nxt;          // candidate, positive
  logic [W-1:0] d_r, d_nxt;          // trial divisor
  logic [W-1:0] q_r, q_nxt;          // dividend shift register
  logic [W:0] rem_r, rem_nxt;        // partial remainder
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic res_r, res_nxt;
  logic [2*W-1:0] sq;
  logic [W:0] trial;
  logic [W:0] shifted;

  assign sq = {{W{1'b0}}, d_r} * {{W{1'b0}}, d_r};
  assign shifted = {rem_r[W-1:0], q_r[W-1]};
  assign trial = shifted - {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    d_nxt = d_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          n_nxt = value;
          d_nxt = W'(2);
          if (value[W-1] || value < W'(2)) begin
            res_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TRY;
          end
        end
      end
      S_TRY: begin
        if (sq > {{W{1'b0}}, n_r}) begin
          res_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          q_nxt = n_r;
          rem_nxt = '0;
          cnt_nxt = CW'(W);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        q_nxt = {q_r[W-2:0], 1'b0};
        rem_nxt = trial[W] ? shifted : trial;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          if ((trial[W] ? shifted : trial) == '0) begin
            res_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            d_nxt = d_r + 1'b1;
            state_nxt = S_TRY;
          end
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r <= n_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign rsp.busy = (state_r != S_IDLE);
  assign rsp.done = (state_r == S_DONE);
  assign rsp.is_prime = res_r;

  `LSSC_ASSERT_NEXT(a_start_leaves_idle, state_r == S_IDLE && req.start, state_r != S_IDLE)
  `LSSC_ASSERT_IMP(a_div_count_nonzero, state_r == S_DIV, cnt_r != '0)
  `LSSC_ASSERT_NEXT(a_done_one_cycle, state_r == S_DONE, state_r == S_IDLE)
endmodule

### src/lifo_stack_with_search_and_counts.sv
// top level of the lifo stack with search, pair and prime counts
// depends on lssc_pkg, lssc_prime and the assertion header
//
// usage: one item on the in_ channel (valid/ready) is a push, pop or search;
// each item gives exactly one result on the out_ channel (valid/ready).
// the block works on one item at a time and drops in_ready while busy.
// pop reads the top entry; search walks the stored entries one per cycle,
// from the top down through the rd_r memory read port; push waits for the
// primality test, which tries trial divisors d up to sqrt(value), one after
// another in the shared restoring divider.
// push also reads the old top entry for the pair count.
// reset (rst_n low, synchronous) empties the stack and clears both counts;
// memory contents are not cleared, only entries below the fill level are used.
// a stalled receiver holds the result in the output register and the block
// takes no new item until it is taken.
`include "lifo_stack_with_search_and_counts_assert.svh"
module lifo_stack_with_search_and_counts #(
  parameter int STACK_DEPTH = lssc_pkg::StackDepth,
  parameter int VALUE_WIDTH = lssc_pkg::ValueWidth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic signed [VALUE_WIDTH-1:0] in_push_value,
  input  logic signed [VALUE_WIDTH-1:0] in_search_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_popped_value,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [$clog2(STACK_DEPTH)-1:0] out_found_position,
  output logic [$clog2(STACK_DEPTH+1)-1:0] out_stack_depth,
  output logic [$clog2(STACK_DEPTH)-1:0] out_ascending_pairs,
  output logic [$clog2(STACK_DEPTH+1)-1:0] out_prime_count
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W = VALUE_WIDTH;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;   // memory read issued
  localparam logic [2:0] S_PRIME = 3'd2;  // waiting for primality test
  localparam logic [2:0] S_POP = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] pairs_r, pairs_nxt;
  logic [CW-1:0] primes_r, primes_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic signed [W-1:0] val_r, val_nxt;    // push value or search key
  logic [CW-1:0] idx_r, idx_nxt;          // search walk index, entries left
  logic first_r, first_nxt;               // first search read pending

  // memory: value plus prime flag
  logic [W:0] mem [STACK_DEPTH];
  logic [W:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [AW-1:0] rd2_r;                   // second read: entry below the top
  logic [W:0] below_r;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [W:0] wr_data;

  // result register
  logic ov_r, ov_nxt;
  logic signed [W-1:0] o_pop_r, o_pop_nxt;
  logic [1:0] o_st_r, o_st_nxt;
  logic o_fnd_r, o_fnd_nxt;
  logic [AW-1:0] o_pos_r, o_pos_nxt;

  lssc_pkg::prime_req_t preq;
  lssc_pkg::prime_rsp_t prsp;

  lssc_prime #(.VALUE_WIDTH(W)) u_prime (
    .clk(clk), .rst_n(rst_n), .req(preq), .value(val_r), .rsp(prsp)
  );

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  logic acc;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
    below_r <= mem[rd2_r];
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    pairs_nxt = pairs_r;
    primes_nxt = primes_r;
    kind_nxt = kind_r;
    val_nxt = val_r;
    idx_nxt = idx_r;
    first_nxt = first_r;
    ov_nxt = ov_r;
    o_pop_nxt = o_pop_r;
    o_st_nxt = o_st_r;
    o_fnd_nxt = o_fnd_r;
    o_pos_nxt = o_pos_r;
    rd_en = 1'b0;
    rd_addr = AW'(fill_r - 1'b1);
    wr_en = 1'b0;
    wr_addr = AW'(fill_r);
    wr_data = {prsp.is_prime, val_r};
    preq.start = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          kind_nxt = in_kind;
          o_pop_nxt = '0;
          o_st_nxt = lssc_pkg::ST_OK;
          o_fnd_nxt = 1'b0;
          o_pos_nxt = '0;
          priority if (in_kind == lssc_pkg::KIND_PUSH) begin
            val_nxt = in_push_value;
            if (fill_r == CW'(STACK_DEPTH)) begin
              o_st_nxt = lssc_pkg::ST_FULL;
              state_nxt = S_OUT;
            end else begin
              rd_en = 1'b1;   // old top for pair count
              state_nxt = S_READ;
            end
          end else if (in_kind == lssc_pkg::KIND_POP) begin
            if (fill_r == '0) begin
              o_st_nxt = lssc_pkg::ST_EMPTY;
              state_nxt = S_OUT;
            end else begin
              rd_en = 1'b1;
              state_nxt = S_READ;
            end
          end else if (in_kind == lssc_pkg::KIND_SEARCH) begin
            val_nxt = in_search_key;
            idx_nxt = fill_r;
            first_nxt = 1'b1;
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_READ: begin
        if (kind_r == lssc_pkg::KIND_PUSH) begin
          preq.start = 1'b1;
          state_nxt = S_PRIME;
        end else begin
          state_nxt = S_POP;  // below_r settles with rd2 at fill-2
        end
      end
      S_PRIME: begin
        if (prsp.done) begin
          wr_en = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (fill_r != '0 && $signed(val_r) < $signed(rd_r[W-1:0]))
            pairs_nxt = pairs_r + 1'b1;
          if (prsp.is_prime) primes_nxt = primes_r + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_POP: begin
        o_pop_nxt = rd_r[W-1:0];
        fill_nxt = fill_r - 1'b1;
        if (fill_r > CW'(1) && $signed(rd_r[W-1:0]) < $signed(below_r[W-1:0]))
          pairs_nxt = pairs_r - 1'b1;
        if (rd_r[W]) primes_nxt = primes_r - 1'b1;
        state_nxt = S_OUT;
      end
      S_SRCH: begin
        // one entry per cycle from the top down; rd_r holds entry idx_r
        if (!first_r && rd_r[W-1:0] == val_r) begin
          o_fnd_nxt = 1'b1;
          o_pos_nxt = AW'(fill_r - 1'b1 - idx_r);
          state_nxt = S_OUT;
        end else if (idx_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(idx_r - 1'b1);
          idx_nxt = idx_r - 1'b1;
          first_nxt = 1'b0;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      pairs_r <= '0;
      primes_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      pairs_r <= pairs_nxt;
      primes_r <= primes_nxt;
      ov_r <= ov_nxt;
    end
    kind_r <= kind_nxt;
    val_r <= val_nxt;
    idx_r <= idx_nxt;
    first_r <= first_nxt;
    o_pop_r <= o_pop_nxt;
    o_st_r <= o_st_nxt;
    o_fnd_r <= o_fnd_nxt;
    o_pos_r <= o_pos_nxt;
    rd2_r <= AW'(fill_r - CW'(2));
  end

  assign out_valid = ov_r;
  assign out_popped_value = o_pop_r;
  assign out_status = o_st_r;
  assign out_found = o_fnd_r;
  assign out_found_position = o_pos_r;
  assign out_stack_depth = fill_r;
  assign out_ascending_pairs = pairs_r;
  assign out_prime_count = primes_r;

  `LSSC_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CW'(STACK_DEPTH))
  `LSSC_ASSERT_IMP(a_primes_bound, 1'b1, primes_r <= fill_r)
  `LSSC_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready)
  `LSSC_ASSERT_IMP(a_prime_idle, state_r == S_IDLE, !prsp.busy)
  `LSSC_ASSERT_NEXT(a_out_hold, ov_r && !out_ready, ov_r && $stable(o_st_r))
endmodule
